// ===== rtl/rmba_pkg.sv =====
// ----------------------------------------------------------------------------
// rmba_pkg
// Shared types, constants and the fixed memory contents of the
// read-memory-by-address diagnostic service.
// ----------------------------------------------------------------------------
package rmba_pkg;

  localparam int MEM_BYTES_DEF    = 1024;
  localparam int MAX_RESPONSE_DEF = 64;

  localparam logic [7:0] SID_SERVICE     = 8'h23;
  localparam logic [7:0] SID_NEGATIVE    = 8'h7F;
  localparam logic [7:0] POSITIVE_OFFSET = 8'h40;
  localparam logic [7:0] SID_POSITIVE    = SID_SERVICE + POSITIVE_OFFSET;

  localparam logic [7:0] MIN_LENGTH    = 8'd4;
  localparam logic [3:0] MAX_FIELD_LEN = 4'd4;

  // Word index of the security register within the configuration space.
  localparam logic REG_SECURITY = 1'b0;

  // Number of leading memory bytes that hold the fill pattern.
  localparam logic [31:0] PATTERN_BYTES = 32'd16;

  typedef enum logic [7:0] {
    NRC_NONE   = 8'h00,
    NRC_LENGTH = 8'h13,
    NRC_RANGE  = 8'h31,
    NRC_DENIED = 8'h33
  } nrc_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_SUM,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  // Request fields gathered while the bytes arrive.
  typedef struct packed {
    logic [7:0]  byte_count;
    logic [3:0]  addr_len;
    logic [3:0]  size_len;
    logic [31:0] size_acc;
  } req_info_t;

  // Outcome of the request checks.
  typedef struct packed {
    logic negative;
    nrc_t code;
  } verdict_t;

  // The memory is never written, so its contents are a fixed function of
  // the address: the first sixteen bytes repeat AA BB CC DD EE FF.
  function automatic logic [7:0] mem_init_byte(input logic [31:0] addr);
    logic [7:0] val;
    val = 8'h00;
    if (addr < PATTERN_BYTES) begin
      case (addr[3:0])
        4'd0, 4'd6, 4'd12: val = 8'hAA;
        4'd1, 4'd7, 4'd13: val = 8'hBB;
        4'd2, 4'd8, 4'd14: val = 8'hCC;
        4'd3, 4'd9, 4'd15: val = 8'hDD;
        4'd4, 4'd10:       val = 8'hEE;
        4'd5, 4'd11:       val = 8'hFF;
        default:           val = 8'h00;
      endcase
    end
    return val;
  endfunction

endpackage

// ===== rtl/rmba_req_if.sv =====
// ----------------------------------------------------------------------------
// rmba_req_if
// Valid/ready channel that carries one request byte per transfer.
// ----------------------------------------------------------------------------
interface rmba_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] request_byte;
  logic       request_last;

  modport source (output valid, output request_byte, output request_last, input ready);
  modport sink   (input valid, input request_byte, input request_last, output ready);
endinterface

// ===== rtl/rmba_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rmba_rsp_if
// Valid/ready channel that carries one response byte per transfer.
// ----------------------------------------------------------------------------
interface rmba_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] response_byte;
  logic       is_negative;
  logic       response_last;

  modport source (output valid, output response_byte, output is_negative,
                  output response_last, input ready);
  modport sink   (input valid, input response_byte, input is_negative,
                  input response_last, output ready);
endinterface

// ===== rtl/read_memory_by_address_service.sv =====
// ----------------------------------------------------------------------------
// read_memory_by_address_service
// Diagnostic read-memory-by-address service: collects a request byte by byte,
// validates it and streams back a negative or a positive response.
// ----------------------------------------------------------------------------
// Sequence: request bytes are taken one per cycle while collecting; after the
//   final byte the sum state forms the range sum, the decide state runs the
//   checks and the emit state loads the response bytes into the output register.
// Throughput: one response byte per cycle unless out_rsp.ready stalls it (3 for a
//   negative response, size+1 for a positive one), set by the single shared 33-bit adder and sequencer.
// Reset (rst_n, synchronous, active low) clears the sequencer, the request
//   fields, the output valid and the security register; no clearing pass.
module read_memory_by_address_service #(
  parameter int MEM_BYTES    = rmba_pkg::MEM_BYTES_DEF,
  parameter int MAX_RESPONSE = rmba_pkg::MAX_RESPONSE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rmba_req_if.sink     in_req,
  rmba_rsp_if.source   out_rsp,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  // Width of the response byte counter: it must reach MAX_RESPONSE - 1.
  localparam int CNT_W = $clog2(MAX_RESPONSE + 1);

  rmba_pkg::state_t state_r, state_nxt;

  // Configuration register.
  logic security_r;

  // Request fields, built up as the bytes arrive.
  logic [7:0]  byte_count_r;
  logic [3:0]  addr_len_r;
  logic [3:0]  size_len_r;
  logic [31:0] address_acc_r;
  logic [31:0] size_acc_r;

  // Response sequencing.
  logic [32:0]      sum_r;
  logic             neg_r;
  rmba_pkg::nrc_t   code_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] last_idx_r;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_neg_r;
  logic       out_last_r;

  // Shared adder: forms address + size for the range check, and later steps
  // the read pointer through memory one byte at a time.
  logic [32:0] add_b;
  logic [32:0] add_y;

  logic               in_fire;
  logic               cfg_write;
  logic               load;
  logic               is_final;
  logic [7:0]         emit_byte;
  logic [4:0]         field_end;
  rmba_pkg::req_info_t req_info;
  rmba_pkg::verdict_t  verdict;

  assign add_b = (state_r == rmba_pkg::ST_SUM) ? {1'b0, size_acc_r} : 33'd1;
  assign add_y = {1'b0, address_acc_r} + add_b;

  assign in_fire   = in_req.valid && in_req.ready;
  assign field_end = {1'b0, addr_len_r} + {1'b0, size_len_r};

  assign req_info.byte_count = byte_count_r;
  assign req_info.addr_len   = addr_len_r;
  assign req_info.size_len   = size_len_r;
  assign req_info.size_acc   = size_acc_r;

  rmba_check #(
    .MEM_BYTES    (MEM_BYTES),
    .MAX_RESPONSE (MAX_RESPONSE)
  ) u_check (
    .req              (req_info),
    .range_end        (sum_r),
    .security_granted (security_r),
    .verdict          (verdict)
  );

  // ---------------------------------------------------------------------------
  // Configuration port. Every access completes at once; a write lands at the
  // access phase and only the first word holds a register.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == rmba_pkg::REG_SECURITY) ? {31'd0, security_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      security_r <= 1'b0;
    end else if (cfg_write && (cfg_paddr[2] == rmba_pkg::REG_SECURITY)) begin
      security_r <= cfg_pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rmba_pkg::ST_COLLECT: begin
        if (in_fire && in_req.request_last) begin
          state_nxt = rmba_pkg::ST_SUM;
        end
      end
      rmba_pkg::ST_SUM:    state_nxt = rmba_pkg::ST_DECIDE;
      rmba_pkg::ST_DECIDE: state_nxt = rmba_pkg::ST_EMIT;
      rmba_pkg::ST_EMIT: begin
        if (load && is_final) begin
          state_nxt = rmba_pkg::ST_COLLECT;
        end
      end
      default: state_nxt = rmba_pkg::ST_COLLECT;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs. Request bytes are taken only while collecting; in ST_EMIT a
  // response byte is loaded whenever the output register is free or is being
  // emptied in the same cycle, so a finished byte never blocks the next one.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_req.ready = 1'b0;
    load         = 1'b0;
    case (state_r)
      rmba_pkg::ST_COLLECT: in_req.ready = 1'b1;
      rmba_pkg::ST_EMIT:    load = !out_valid_r || out_rsp.ready;
      default: begin
        in_req.ready = 1'b0;
        load         = 1'b0;
      end
    endcase
  end

  // The negative form is the fixed header and the code; the positive form is
  // the positive service id and then the memory bytes from the read pointer.
  always_comb begin
    is_final = (idx_r == last_idx_r);
    if (neg_r) begin
      case (idx_r)
        CNT_W'(0): emit_byte = rmba_pkg::SID_NEGATIVE;
        CNT_W'(1): emit_byte = rmba_pkg::SID_SERVICE;
        default:   emit_byte = code_r;
      endcase
    end else if (idx_r == '0) begin
      emit_byte = rmba_pkg::SID_POSITIVE;
    end else begin
      emit_byte = rmba_pkg::mem_init_byte(address_acc_r);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers and request collection.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rmba_pkg::ST_COLLECT;
      out_valid_r   <= 1'b0;
      byte_count_r  <= 8'd0;
      addr_len_r    <= 4'd0;
      size_len_r    <= 4'd0;
      address_acc_r <= 32'd0;
      size_acc_r    <= 32'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;

      if (in_fire) begin
        // The first byte is the format byte; then come the address bytes,
        // then the size bytes, both most significant first. Any further
        // bytes only count towards the length.
        if (byte_count_r == 8'd0) begin
          addr_len_r <= in_req.request_byte[3:0];
          size_len_r <= in_req.request_byte[7:4];
        end else if (byte_count_r <= {4'd0, addr_len_r}) begin
          address_acc_r <= {address_acc_r[23:0], in_req.request_byte};
        end else if (byte_count_r <= {3'd0, field_end}) begin
          size_acc_r <= {size_acc_r[23:0], in_req.request_byte};
        end
        if (byte_count_r != 8'hFF) begin
          byte_count_r <= byte_count_r + 8'd1;
        end
      end

      if (load) begin
        if (is_final) begin
          // Response complete: the request fields return to their idle values.
          byte_count_r  <= 8'd0;
          addr_len_r    <= 4'd0;
          size_len_r    <= 4'd0;
          address_acc_r <= 32'd0;
          size_acc_r    <= 32'd0;
        end else if (!neg_r && (idx_r != '0)) begin
          // A memory byte has gone out; advance the read pointer.
          address_acc_r <= add_y[31:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response payload registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == rmba_pkg::ST_SUM) begin
      sum_r <= add_y;
    end
    if (state_r == rmba_pkg::ST_DECIDE) begin
      neg_r      <= verdict.negative;
      code_r     <= verdict.code;
      idx_r      <= '0;
      last_idx_r <= verdict.negative ? CNT_W'(2) : size_acc_r[CNT_W-1:0];
    end else if (load) begin
      idx_r <= idx_r + CNT_W'(1);
    end
    if (load) begin
      out_byte_r <= emit_byte;
      out_neg_r  <= neg_r;
      out_last_r <= is_final;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.response_byte = out_byte_r;
  assign out_rsp.is_negative   = out_neg_r;
  assign out_rsp.response_last = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // The byte counter never runs past the final byte of the response.
  a_idx_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmba_pkg::ST_EMIT) |-> (idx_r <= last_idx_r))
    else $error("response byte index beyond the final byte");

  // Memory bytes are only ever read from within the memory.
  a_read_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmba_pkg::ST_EMIT && !neg_r && idx_r != '0) |->
      ({1'b0, address_acc_r} < 33'(MEM_BYTES)))
    else $error("memory read outside the memory");

  // Once the final byte is loaded, the block is back to collecting with a
  // cleared request.
  a_clear_after_final : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmba_pkg::ST_EMIT && load && is_final) |=>
      (state_r == rmba_pkg::ST_COLLECT && byte_count_r == 8'd0 &&
       address_acc_r == 32'd0 && size_acc_r == 32'd0))
    else $error("request not cleared after the response");

  // A positive response never exceeds the permitted size.
  a_size_limit : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmba_pkg::ST_EMIT && !neg_r) |->
      ({{(32-CNT_W){1'b0}}, last_idx_r} <= 32'(MAX_RESPONSE - 1)))
    else $error("positive response longer than permitted");

endmodule

// ===== rtl/rmba_check.sv =====
// ----------------------------------------------------------------------------
// rmba_check
// Request validation: length, format, range and security checks in their
// order of priority, giving the negative response code if any fails.
// ----------------------------------------------------------------------------
module rmba_check #(
  parameter int MEM_BYTES    = rmba_pkg::MEM_BYTES_DEF,
  parameter int MAX_RESPONSE = rmba_pkg::MAX_RESPONSE_DEF
) (
  input  rmba_pkg::req_info_t req,
  input  logic [32:0]         range_end,
  input  logic                security_granted,
  output rmba_pkg::verdict_t  verdict
);

  logic [4:0] need;
  logic       short_req;
  logic       bad_format;
  logic       too_large;

  // The byte count already includes the final byte; when it has saturated
  // the true length is above any length that a check asks for.
  assign need       = 5'd1 + {1'b0, req.addr_len} + {1'b0, req.size_len};
  assign short_req  = (req.byte_count < rmba_pkg::MIN_LENGTH) ||
                      (req.byte_count < {3'b000, need});
  assign bad_format = (req.addr_len == 4'd0) || (req.addr_len > rmba_pkg::MAX_FIELD_LEN) ||
                      (req.size_len == 4'd0) || (req.size_len > rmba_pkg::MAX_FIELD_LEN);
  assign too_large  = (req.size_acc > 32'(MAX_RESPONSE - 1)) ||
                      (range_end > 33'(MEM_BYTES));

  always_comb begin
    verdict.negative = 1'b1;
    verdict.code     = rmba_pkg::NRC_NONE;
    if (short_req) begin
      verdict.code = rmba_pkg::NRC_LENGTH;
    end else if (bad_format || too_large) begin
      verdict.code = rmba_pkg::NRC_RANGE;
    end else if (!security_granted) begin
      verdict.code = rmba_pkg::NRC_DENIED;
    end else begin
      verdict.negative = 1'b0;
    end
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the read-memory-by-address service. Requests are
// streamed in byte by byte, each accepted byte updates a shadow copy of the
// request decoder, and every response transfer is compared against the
// response that the shadow decoder worked out.
// ----------------------------------------------------------------------------
module tb;

  // Register map of the configuration port.
  localparam logic [2:0] SECURITY_ADDR = {rmba_pkg::REG_SECURITY, 2'b00};
  localparam logic [2:0] REG_SPARE     = 3'd4;

  localparam int RANDOM_ITEMS  = 50;
  localparam int SETTLE_CYCLES = 8;
  localparam int RUN_LIMIT     = 2000000;

  // Clock and reset. Reset is held only at the start of the run.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  // Channels and configuration port.
  rmba_req_if req_ch ();
  rmba_rsp_if rsp_ch ();

  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  read_memory_by_address_service uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (req_ch),
    .out_rsp     (rsp_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // One request byte as it waits in the send queue.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } req_item_t;

  // One response byte that the decoder says must come out.
  typedef struct {
    logic [7:0] data;
    logic       negative;
    logic       last;
  } rsp_item_t;

  req_item_t  pending_q [$];
  rsp_item_t  awaited_q [$];
  logic [7:0] frame_q [$];

  // Shadow copy of the block's request decoder and its one register.
  logic        security_q;
  logic [7:0]  req_count;
  logic [3:0]  addr_len_q;
  logic [3:0]  size_len_q;
  logic [31:0] addr_acc_q;
  logic [31:0] size_acc_q;
  logic [7:0]  rom_image [0:rmba_pkg::MEM_BYTES_DEF-1];

  // Bookkeeping for the run summary and the verdict.
  int errors     = 0;
  int frames     = 0;
  int rand_items = 0;
  int rsp_beats  = 0;
  int pos_rsps   = 0;
  int neg_rsps   = 0;

  // When calm is set neither side inserts any idle cycles.
  logic calm = 1'b0;

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_rsp(logic [7:0] data, logic negative, logic last);
    awaited_q.push_back('{data: data, negative: negative, last: last});
  endfunction

  // A negative response is always the same three bytes, only the code varies.
  function automatic void push_negative(rmba_pkg::nrc_t code);
    push_rsp(rmba_pkg::SID_NEGATIVE, 1'b1, 1'b0);
    push_rsp(rmba_pkg::SID_SERVICE, 1'b1, 1'b0);
    push_rsp(code, 1'b1, 1'b1);
  endfunction

  // Takes one accepted request byte into the shadow decoder. On the byte
  // marked last the request is judged and the whole response is queued.
  function automatic void decode_request_byte(logic [7:0] data, logic is_last);
    int unsigned pos;
    int unsigned length;
    int unsigned need;
    int unsigned n;
    logic [32:0] span;
    pos = req_count;
    if (pos == 0) begin
      addr_len_q = data[3:0];
      size_len_q = data[7:4];
    end else if (pos <= addr_len_q) begin
      addr_acc_q = {addr_acc_q[23:0], data};
    end else if (pos <= addr_len_q + size_len_q) begin
      size_acc_q = {size_acc_q[23:0], data};
    end
    // The byte counter sticks at its top value on very long requests.
    if (req_count != 8'hFF) req_count = req_count + 8'd1;
    if (!is_last) return;

    length = pos + 1;
    need   = 1 + addr_len_q + size_len_q;
    span   = {1'b0, addr_acc_q} + {1'b0, size_acc_q};
    if (length < rmba_pkg::MIN_LENGTH || length < need) begin
      push_negative(rmba_pkg::NRC_LENGTH);
    end else if (addr_len_q == 4'd0 || addr_len_q > rmba_pkg::MAX_FIELD_LEN ||
                 size_len_q == 4'd0 || size_len_q > rmba_pkg::MAX_FIELD_LEN) begin
      push_negative(rmba_pkg::NRC_RANGE);
    end else if (size_acc_q > rmba_pkg::MAX_RESPONSE_DEF - 1 ||
                 span > rmba_pkg::MEM_BYTES_DEF) begin
      push_negative(rmba_pkg::NRC_RANGE);
    end else if (!security_q) begin
      push_negative(rmba_pkg::NRC_DENIED);
    end else begin
      n = size_acc_q;
      push_rsp(rmba_pkg::SID_POSITIVE, 1'b0, n == 0);
      for (int i = 0; i < n; i++)
        push_rsp(rom_image[addr_acc_q + i], 1'b0, i + 1 == n);
    end
    req_count  = 8'd0;
    addr_len_q = 4'd0;
    size_len_q = 4'd0;
    addr_acc_q = 32'd0;
    size_acc_q = 32'd0;
  endfunction

  // Request driver. A new byte is presented whenever the previous one has
  // been transferred (or none was pending) and the current gap has run out.
  int unsigned send_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid        <= 1'b0;
      req_ch.request_byte <= 8'h00;
      req_ch.request_last <= 1'b0;
      send_gap   = 0;
      req_count  = 8'd0;
      addr_len_q = 4'd0;
      size_len_q = 4'd0;
      addr_acc_q = 32'd0;
      size_acc_q = 32'd0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        decode_request_byte(req_ch.request_byte, req_ch.request_last);
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          req_item_t item;
          item = pending_q.pop_front();
          req_ch.valid        <= 1'b1;
          req_ch.request_byte <= item.data;
          req_ch.request_last <= item.last;
          send_gap = pick_gap();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor. Every transfer is compared with the oldest awaited
  // byte; ready is dropped at random to stall the block's output.
  int unsigned stall_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_beats++;
        if (awaited_q.size() == 0) begin
          $error("response_byte: no byte awaited, got %h", rsp_ch.response_byte);
          errors++;
        end else begin
          rsp_item_t want;
          want = awaited_q.pop_front();
          if (rsp_ch.response_byte !== want.data) begin
            $error("response_byte: expected %h, got %h", want.data, rsp_ch.response_byte);
            errors++;
          end
          if (rsp_ch.is_negative !== want.negative) begin
            $error("is_negative: expected %b, got %b", want.negative, rsp_ch.is_negative);
            errors++;
          end
          if (rsp_ch.response_last !== want.last) begin
            $error("response_last: expected %b, got %b", want.last, rsp_ch.response_last);
            errors++;
          end
        end
        if (rsp_ch.response_last === 1'b1) begin
          if (rsp_ch.is_negative) neg_rsps++;
          else pos_rsps++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < 15) stall_left = pick_gap();
      end
    end
  end

  // Moves the assembled frame into the send queue, marking its final byte.
  task automatic queue_frame();
    for (int i = 0; i < frame_q.size(); i++)
      pending_q.push_back('{data: frame_q[i], last: i == frame_q.size() - 1});
    frames++;
    frame_q.delete();
  endtask

  // Appends a big-endian field of len bytes. Bytes above the fourth fall out
  // of the block's 32-bit accumulator, so they are simply random.
  task automatic add_field(int len, logic [31:0] value);
    for (int k = len - 1; k >= 0; k--)
      frame_q.push_back(k < 4 ? value[8*k +: 8] : 8'($urandom));
  endtask

  // Waits until every byte has been sent and every response byte has come,
  // then lets the block run on a little in case a request is still in flight.
  task automatic settle();
    while (pending_q.size() != 0 || req_ch.valid || awaited_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Two-phase write on the configuration port; only issued while idle.
  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == SECURITY_ADDR) security_q = value[0];
  endtask

  // Builds one random request. Most are well formed with random address and
  // size; the rest have bad length nibbles, trailing bytes, a cut-off end or
  // are plain noise.
  task automatic gen_request();
    int unsigned r;
    int unsigned shape;
    int unsigned alen;
    int unsigned slen;
    int unsigned keep;
    logic [31:0] addr;
    logic [31:0] size;
    r     = $urandom_range(0, 99);
    shape = $urandom_range(0, 99);
    alen  = $urandom_range(1, 4);
    slen  = $urandom_range(1, 4);
    if (r < 5) alen = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(5, 15);
    else if (r < 10) slen = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(5, 15);

    r = $urandom_range(0, 99);
    if (r < 70) addr = $urandom_range(0, rmba_pkg::MEM_BYTES_DEF - 1);
    else if (r < 85) addr = $urandom_range(rmba_pkg::MEM_BYTES_DEF - 64,
                                           rmba_pkg::MEM_BYTES_DEF - 1);
    else addr = $urandom;

    r = $urandom_range(0, 99);
    if (r < 10) size = 0;
    else if (r < 85) size = $urandom_range(1, rmba_pkg::MAX_RESPONSE_DEF - 1);
    else if (r < 93) size = $urandom_range(rmba_pkg::MAX_RESPONSE_DEF, 255);
    else size = $urandom;

    frame_q.push_back({slen[3:0], alen[3:0]});
    add_field(alen, addr);
    add_field(slen, size);
    if (shape < 10) begin
      repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
    end else if (shape < 18 && frame_q.size() > 1) begin
      keep = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > keep) void'(frame_q.pop_back());
    end else if (shape < 22) begin
      frame_q.delete();
      repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
    end
    rand_items += frame_q.size();
    queue_frame();
  endtask

  // Stimulus sequence.
  initial begin
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = SECURITY_ADDR;
    cfg_pwdata  = 32'd0;
    security_q  = 1'b0;
    // Fixed memory image: AA BB CC DD EE FF repeated over the first sixteen
    // bytes, zero above.
    for (int i = 0; i < rmba_pkg::MEM_BYTES_DEF; i++) rom_image[i] = 8'h00;
    for (int i = 0; i < 16; i++) rom_image[i] = 8'hAA + 8'(17 * (i % 6));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With security access withheld a valid request must be denied.
    write_reg(SECURITY_ADDR, 32'd0);
    frame_q = {8'h11, 8'h00, 8'h04, 8'h00};
    queue_frame();
    settle();

    write_reg(SECURITY_ADDR, 32'd1);
    // Too short overall, then cut off before the fields it announces.
    frame_q = {8'h11};
    queue_frame();
    frame_q = {8'h44, 8'h00, 8'h00, 8'h00};
    queue_frame();
    frame_q = {8'hFF, 8'h00, 8'h00, 8'h00};
    queue_frame();
    // Address length of zero, then an address length above four.
    frame_q = {8'h10, 8'h00, 8'h00, 8'h00};
    queue_frame();
    frame_q = {8'h15, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06};
    queue_frame();
    // One byte over the response limit, then exactly at it.
    frame_q = {8'h21, 8'h00, 8'h00, 8'h40};
    queue_frame();
    frame_q = {8'h21, 8'h00, 8'h00, 8'h3F};
    queue_frame();
    // A read ending exactly at the top of memory, and one byte past it.
    frame_q = {8'h12, 8'h03, 8'hE0, 8'h20};
    queue_frame();
    frame_q = {8'h12, 8'h03, 8'hE1, 8'h20};
    queue_frame();
    // The address plus size only overflows in the 33rd bit.
    frame_q = {8'h14, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01};
    queue_frame();
    // Zero size gives the positive header alone.
    frame_q = {8'h21, 8'h05, 8'h00, 8'h00};
    queue_frame();
    // Whole pattern region with four-byte fields, then trailing bytes.
    frame_q = {8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10};
    queue_frame();
    frame_q = {8'h11, 8'h0A, 8'h06, 8'hAB, 8'hCD};
    queue_frame();
    // A request long enough to saturate the byte counter.
    frame_q = {8'h11, 8'h00, 8'h02};
    repeat (255) frame_q.push_back(8'($urandom));
    queue_frame();
    settle();

    // A write outside the register map must leave security access alone.
    write_reg(REG_SPARE, 32'd0);
    frame_q = {8'h11, 8'h02, 8'h03, 8'h00};
    queue_frame();
    settle();

    // Random phases: security on, off, on without any idling, on again.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(SECURITY_ADDR, (ph == 1) ? 32'd0 : 32'd1);
      calm = (ph == 2);
      while (rand_items < RANDOM_ITEMS * (ph + 1) / 4) begin
        gen_request();
        // Now and then hold the sender back until the block has drained.
        if ($urandom_range(0, 19) == 0) settle();
      end
      settle();
    end
    calm = 1'b0;

    $display("Ran %0d requests (%0d random bytes) with security access off and on.",
             frames, rand_items);
    $display("Checked %0d response transfers: %0d positive and %0d negative responses.",
             rsp_beats, pos_rsps, neg_rsps);
    if (errors == 0 && awaited_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #RUN_LIMIT;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rmba_pkg.sv
rtl/rmba_req_if.sv
rtl/rmba_rsp_if.sv
rtl/rmba_check.sv
rtl/read_memory_by_address_service.sv
sim/tb.sv
